// ===== hdl/cha_pkg.sv =====
// shared types and constants for the convex hull area core
// no dependencies
package cha_pkg;

	localparam int COORD_W   = 16;
	localparam int IDX_W     = 8;
	localparam int CNT_W     = IDX_W + 1;
	localparam int AREA_W    = 33;
	localparam int DEPTH     = 1 << IDX_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic [AREA_W-1:0] area_twice;
		logic [CNT_W-1:0]  hull_size;
		logic              dropped;
	} result_t;

endpackage

// ===== hdl/convex_hull_area_core.sv =====
// after the last point is loaded, the sort, scan and area pass run in turn,
// the insertion sort working on one memory port
// throughput: one point per cycle while loading, one point set at a time
// reset: arst_n clears control state; point and index memories are not cleared
// convex hull area core, uses cha_pkg
module convex_hull_area_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             point_valid,
	output logic             point_stall,
	input  cha_pkg::point_t  point,
	output logic             result_valid,
	input  logic             result_stall,
	output cha_pkg::result_t result
);
	import cha_pkg::*;

	typedef enum logic [29:0] {
		ST_LOAD  = 30'd1 << 0,
		ST_G_RD  = 30'd1 << 1,
		ST_G_WT  = 30'd1 << 2,
		ST_I_CHK = 30'd1 << 3,
		ST_I_IDX = 30'd1 << 4,
		ST_I_PT  = 30'd1 << 5,
		ST_I_DEC = 30'd1 << 6,
		ST_D_RD  = 30'd1 << 7,
		ST_D_I   = 30'd1 << 8,
		ST_D_IP  = 30'd1 << 9,
		ST_D_J   = 30'd1 << 10,
		ST_D_JP  = 30'd1 << 11,
		ST_D_DEC = 30'd1 << 12,
		ST_S_RD  = 30'd1 << 13,
		ST_S_P   = 30'd1 << 14,
		ST_S_PP  = 30'd1 << 15,
		ST_S_CHK = 30'd1 << 16,
		ST_S_A   = 30'd1 << 17,
		ST_S_B   = 30'd1 << 18,
		ST_S_BP  = 30'd1 << 19,
		ST_S_DEC = 30'd1 << 20,
		ST_A_RD  = 30'd1 << 21,
		ST_A_I   = 30'd1 << 22,
		ST_A_J   = 30'd1 << 23,
		ST_A_JP  = 30'd1 << 24,
		ST_A_ADD = 30'd1 << 25,
		ST_T1    = 30'd1 << 26,
		ST_T2    = 30'd1 << 27,
		ST_T3    = 30'd1 << 28,
		ST_DONE  = 30'd1 << 29
	} state_t;

	state_t state_q, ret_q;

	logic [2*COORD_W-1:0] pt_mem [DEPTH];
	logic [IDX_W-1:0]     idx_mem [DEPTH];

	logic                 pt_we, idx_we;
	logic [IDX_W-1:0]     pt_waddr, pt_raddr, idx_waddr, idx_raddr, idx_wdata;
	logic [2*COORD_W-1:0] pt_wdata, pt_rdata;
	logic [IDX_W-1:0]     idx_rdata;

	logic [CNT_W-1:0] cnt_q, i_q, n_q, k_q, m_q, top_q;
	logic             ovf_q;
	logic [AREA_W-1:0] area_q;

	logic signed [COORD_W-1:0] anc_x_q, anc_y_q, cur_x_q, cur_y_q;
	logic signed [COORD_W-1:0] o_x_q, o_y_q, a_x_q, a_y_q, b_x_q, b_y_q;
	logic [IDX_W-1:0]          cur_idx_q, q_idx_q;

	logic signed [COORD_W:0]     dax_q, day_q, dbx_q, dby_q;
	logic signed [2*COORD_W+1:0] p1_q, p2_q;
	logic [COORD_W+1:0]          l1a_q, l1b_q;
	logic signed [2*COORD_W+2:0] c_q;
	logic                        la_lt_q;

	logic                        accept;
	logic signed [COORD_W-1:0]   rd_x, rd_y;
	logic [COORD_W:0]            abs_ax, abs_ay, abs_bx, abs_by;
	logic                        ahead, anc_upd, out_free;

	assign accept      = point_valid && !point_stall;
	assign point_stall = (state_q != ST_LOAD);
	assign rd_x        = pt_rdata[COORD_W-1:0];
	assign rd_y        = pt_rdata[2*COORD_W-1:COORD_W];
	assign ahead       = (c_q > 0) || ((c_q == 0) && la_lt_q);
	assign out_free    = !result_valid || !result_stall;
	assign anc_upd     = (cnt_q == '0) || (point.point_y < anc_y_q) ||
		((point.point_y == anc_y_q) && (point.point_x < anc_x_q));

	assign abs_ax = dax_q[COORD_W] ? -dax_q : dax_q;
	assign abs_ay = day_q[COORD_W] ? -day_q : day_q;
	assign abs_bx = dbx_q[COORD_W] ? -dbx_q : dbx_q;
	assign abs_by = dby_q[COORD_W] ? -dby_q : dby_q;

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		pt_rdata <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (idx_we) begin
			idx_mem[idx_waddr] <= idx_wdata;
		end
		idx_rdata <= idx_mem[idx_raddr];
	end

	always_comb begin
		pt_we     = 1'b0;
		pt_waddr  = cnt_q[IDX_W-1:0];
		pt_wdata  = {point.point_y, point.point_x};
		pt_raddr  = idx_rdata;
		idx_we    = 1'b0;
		idx_waddr = k_q[IDX_W-1:0];
		idx_wdata = i_q[IDX_W-1:0];
		idx_raddr = i_q[IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				pt_we = accept && !cnt_q[CNT_W-1];
			end
			ST_G_RD: begin
				pt_raddr = i_q[IDX_W-1:0];
			end
			ST_I_CHK: begin
				idx_we    = (k_q == '0);
				idx_raddr = IDX_W'(k_q - CNT_W'(1));
			end
			ST_I_DEC: begin
				idx_we = 1'b1;
				if (ahead) begin
					idx_wdata = q_idx_q;
				end
			end
			ST_D_IP: begin
				idx_raddr = IDX_W'(i_q + CNT_W'(1));
				idx_we    = ((i_q + CNT_W'(1)) == n_q);
				idx_waddr = m_q[IDX_W-1:0];
				idx_wdata = cur_idx_q;
			end
			ST_D_DEC: begin
				idx_we    = (c_q != 0);
				idx_waddr = m_q[IDX_W-1:0];
				idx_wdata = cur_idx_q;
			end
			ST_S_CHK: begin
				idx_raddr = IDX_W'(top_q - CNT_W'(2));
				idx_we    = (top_q < CNT_W'(2));
				idx_waddr = top_q[IDX_W-1:0];
				idx_wdata = cur_idx_q;
			end
			ST_S_A: begin
				idx_raddr = IDX_W'(top_q - CNT_W'(1));
			end
			ST_S_DEC: begin
				idx_we    = !c_q[2*COORD_W+2];
				idx_waddr = top_q[IDX_W-1:0];
				idx_wdata = cur_idx_q;
			end
			ST_A_I: begin
				idx_raddr = IDX_W'(i_q + CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			ret_q        <= ST_LOAD;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			i_q          <= '0;
			n_q          <= '0;
			k_q          <= '0;
			m_q          <= '0;
			top_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall && state_q != ST_DONE) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (cnt_q[CNT_W-1]) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (point.last_point) begin
							i_q     <= '0;
							n_q     <= '0;
							state_q <= ST_G_RD;
						end
					end
				end
				ST_G_RD: begin
					if (i_q == cnt_q) begin
						i_q     <= '0;
						m_q     <= '0;
						state_q <= ST_D_RD;
					end else begin
						state_q <= ST_G_WT;
					end
				end
				ST_G_WT: begin
					if (rd_x == anc_x_q && rd_y == anc_y_q) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_G_RD;
					end else begin
						k_q     <= n_q;
						state_q <= ST_I_CHK;
					end
				end
				ST_I_CHK: begin
					if (k_q == '0) begin
						n_q     <= n_q + CNT_W'(1);
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_G_RD;
					end else begin
						state_q <= ST_I_IDX;
					end
				end
				ST_I_IDX: state_q <= ST_I_PT;
				ST_I_PT: begin
					ret_q   <= ST_I_DEC;
					state_q <= ST_T1;
				end
				ST_I_DEC: begin
					if (ahead) begin
						k_q     <= k_q - CNT_W'(1);
						state_q <= ST_I_CHK;
					end else begin
						n_q     <= n_q + CNT_W'(1);
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_G_RD;
					end
				end
				ST_D_RD: begin
					if (i_q == n_q) begin
						i_q     <= '0;
						top_q   <= '0;
						state_q <= ST_S_RD;
					end else begin
						state_q <= ST_D_I;
					end
				end
				ST_D_I: state_q <= ST_D_IP;
				ST_D_IP: begin
					if ((i_q + CNT_W'(1)) == n_q) begin
						m_q     <= m_q + CNT_W'(1);
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_D_RD;
					end else begin
						state_q <= ST_D_J;
					end
				end
				ST_D_J: state_q <= ST_D_JP;
				ST_D_JP: begin
					ret_q   <= ST_D_DEC;
					state_q <= ST_T1;
				end
				ST_D_DEC: begin
					if (c_q != 0) begin
						m_q <= m_q + CNT_W'(1);
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= ST_D_RD;
				end
				ST_S_RD: begin
					if (i_q == m_q) begin
						i_q     <= '0;
						state_q <= ST_A_RD;
					end else begin
						state_q <= ST_S_P;
					end
				end
				ST_S_P:  state_q <= ST_S_PP;
				ST_S_PP: state_q <= ST_S_CHK;
				ST_S_CHK: begin
					if (top_q < CNT_W'(2)) begin
						top_q   <= top_q + CNT_W'(1);
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_S_RD;
					end else begin
						state_q <= ST_S_A;
					end
				end
				ST_S_A: state_q <= ST_S_B;
				ST_S_B: state_q <= ST_S_BP;
				ST_S_BP: begin
					ret_q   <= ST_S_DEC;
					state_q <= ST_T1;
				end
				ST_S_DEC: begin
					if (c_q[2*COORD_W+2]) begin
						top_q   <= top_q - CNT_W'(1);
						state_q <= ST_S_CHK;
					end else begin
						top_q   <= top_q + CNT_W'(1);
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_S_RD;
					end
				end
				ST_A_RD: begin
					if ((i_q + CNT_W'(1)) >= top_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_A_I;
					end
				end
				ST_A_I: state_q <= ST_A_J;
				ST_A_J: state_q <= ST_A_JP;
				ST_A_JP: begin
					ret_q   <= ST_A_ADD;
					state_q <= ST_T1;
				end
				ST_A_ADD: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= ST_A_RD;
				end
				ST_T1: state_q <= ST_T2;
				ST_T2: state_q <= ST_T3;
				ST_T3: state_q <= ret_q;
				ST_DONE: begin
					if (out_free) begin
						result_valid <= 1'b1;
						cnt_q        <= '0;
						ovf_q        <= 1'b0;
						top_q        <= '0;
						state_q      <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (accept && !cnt_q[CNT_W-1] && anc_upd) begin
					anc_x_q <= point.point_x;
					anc_y_q <= point.point_y;
				end
				area_q <= '0;
			end
			ST_G_WT: begin
				cur_x_q   <= rd_x;
				cur_y_q   <= rd_y;
				cur_idx_q <= i_q[IDX_W-1:0];
			end
			ST_I_IDX: q_idx_q <= idx_rdata;
			ST_I_PT: begin
				o_x_q <= anc_x_q;
				o_y_q <= anc_y_q;
				a_x_q <= cur_x_q;
				a_y_q <= cur_y_q;
				b_x_q <= rd_x;
				b_y_q <= rd_y;
			end
			ST_D_I:  cur_idx_q <= idx_rdata;
			ST_D_IP: begin
				a_x_q <= rd_x;
				a_y_q <= rd_y;
			end
			ST_D_JP, ST_A_JP: begin
				o_x_q <= anc_x_q;
				o_y_q <= anc_y_q;
				b_x_q <= rd_x;
				b_y_q <= rd_y;
			end
			ST_S_P: cur_idx_q <= idx_rdata;
			ST_S_PP: begin
				cur_x_q <= rd_x;
				cur_y_q <= rd_y;
			end
			ST_S_B: begin
				o_x_q <= rd_x;
				o_y_q <= rd_y;
			end
			ST_S_BP: begin
				a_x_q <= rd_x;
				a_y_q <= rd_y;
				b_x_q <= cur_x_q;
				b_y_q <= cur_y_q;
			end
			ST_A_J: begin
				a_x_q <= rd_x;
				a_y_q <= rd_y;
			end
			ST_A_ADD: begin
				if (c_q > 0) begin
					area_q <= area_q + c_q[AREA_W-1:0];
				end
			end
			ST_T1: begin
				dax_q <= {a_x_q[COORD_W-1], a_x_q} - {o_x_q[COORD_W-1], o_x_q};
				day_q <= {a_y_q[COORD_W-1], a_y_q} - {o_y_q[COORD_W-1], o_y_q};
				dbx_q <= {b_x_q[COORD_W-1], b_x_q} - {o_x_q[COORD_W-1], o_x_q};
				dby_q <= {b_y_q[COORD_W-1], b_y_q} - {o_y_q[COORD_W-1], o_y_q};
			end
			ST_T2: begin
				p1_q  <= dax_q * dby_q;
				p2_q  <= day_q * dbx_q;
				l1a_q <= {1'b0, abs_ax} + {1'b0, abs_ay};
				l1b_q <= {1'b0, abs_bx} + {1'b0, abs_by};
			end
			ST_T3: begin
				c_q     <= {p1_q[2*COORD_W+1], p1_q} - {p2_q[2*COORD_W+1], p2_q};
				la_lt_q <= (l1a_q < l1b_q);
			end
			ST_DONE: begin
				if (out_free) begin
					result.area_twice <= area_q;
					result.hull_size  <= top_q + CNT_W'(1);
					result.dropped    <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/cha_checker.sv =====
// port-level checks for convex_hull_area_core, bound to the top level
// uses cha_pkg
module cha_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             point_valid,
	input logic             point_stall,
	input cha_pkg::point_t  point,
	input logic             result_valid,
	input logic             result_stall,
	input cha_pkg::result_t result
);
	import cha_pkg::*;

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// the anchor is always counted
	a_size_nz: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.hull_size != '0)
		else $error("hull size zero");

	// a nonzero area needs three hull points
	a_area_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.area_twice != '0 |-> result.hull_size >= CNT_W'(3))
		else $error("area with fewer than three points");

	// the last point starts the busy phase
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && point.last_point |=> point_stall)
		else $error("input taken right after last point");

endmodule

bind convex_hull_area_core cha_checker u_cha_checker (.*);
